@@ src/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on the rising clock edge, off during reset
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert a next-cycle implication on the rising clock edge, off during reset
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/dqtt_pkg.sv @@
// Types, constants and codes of the delta queue task timer
package dqtt_pkg;
	localparam int SLOTS = 16;
	localparam int SW = $clog2(SLOTS + 1);
	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] NIL = SW'(SLOTS);

	typedef logic [SW-1:0] ptr_t;

	typedef enum logic [1:0] {
		FN_TICK = 2'd0,
		FN_ADD  = 2'd1,
		FN_DEL  = 2'd2,
		FN_DISP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] first_delay;
		logic [31:0] repeat_period;
		logic [3:0]  target_id;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] slot_id;
		logic       fired;
		logic [1:0] status;
	} out_beat_t;

	// one cell of the queue chain in order from head
	typedef struct packed {
		logic        used;
		logic [SW-1:0] id;
		logic [31:0] delta;
		logic [31:0] period;
	} entry_t;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		CC_HOLD,
		CC_TICK,
		CC_POP,
		CC_INS,
		CC_DEL
	} ccmd_t;

	typedef struct packed {
		ccmd_t         cmd;
		logic [SW-1:0] pos;
		entry_t        ent;
	} cell_ctl_t;
endpackage

@@ src/dqtt_cell.sv @@
// One queue position: holds an entry, shifts toward head or tail with its neighbors
module dqtt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [dqtt_pkg::SW-1:0] my_pos,
	input  dqtt_pkg::cell_ctl_t ctl,
	input  dqtt_pkg::entry_t  left,
	input  dqtt_pkg::entry_t  right,
	output dqtt_pkg::entry_t  ent
);
	import dqtt_pkg::*;

	entry_t ent_q, nxt;

	always_comb begin
		nxt = ent_q;
		unique case (ctl.cmd)
			CC_TICK: begin
				if (my_pos == '0 && ent_q.used && ent_q.delta != 32'd0)
					nxt.delta = ent_q.delta - 32'd1;
			end
			CC_POP: nxt = right;
			CC_DEL: begin
				if (my_pos >= ctl.pos)
					nxt = right;
				if (my_pos == ctl.pos && right.used)
					nxt.delta = ctl.ent.delta;
			end
			CC_INS: begin
				if (my_pos == ctl.pos)
					nxt = ctl.ent;
				else if (my_pos > ctl.pos)
					nxt = left;
				if (my_pos == ctl.pos + 1'b1 && left.used)
					nxt.delta = left.delta - ctl.ent.delta;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= nxt;
		end
	end

	assign ent = ent_q;
endmodule

@@ src/delta_queue_task_timer.sv @@
// Top level of the delta queue task timer: control and chain of queue cells
// Tasks sit in a row of SLOTS cells ordered by due time, head at cell 0, each
// cell holding slot id, delay relative to the cell before, and period. A tick,
// an add on a full table, a delete on an empty queue and a dispatch that frees
// its slot or finds nothing due are answered from idle; add, delete and a
// dispatch that reinserts a periodic task scan the row one cell per cycle for
// the place to change. Free slots form a stack, the slot freed last is handed
// out first. A result waits in an output register; the next beat is taken
// once it has left and the block is back in idle.
module delta_queue_task_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dqtt_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dqtt_pkg::out_beat_t out_data
);
	import dqtt_pkg::*;

	state_t state_q, state_d;
	in_beat_t cmd_q;
	entry_t cells [SLOTS];
	entry_t lefts [SLOTS];
	entry_t rights [SLOTS];
	cell_ctl_t ctl;
	ptr_t free_nxt_q [SLOTS];
	ptr_t free_hd_q, free_hd_d;
	logic rel_en;
	ptr_t rel_id;
	logic [SW-1:0] idx_q, idx_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] per_q;
	logic [SW-1:0] nid_q, nid_d;
	logic ins_q, ins_d;
	logic [31:0] per_d;
	logic out_v_q;
	out_beat_t out_q, out_d;
	logic out_load;
	logic any_free;
	entry_t cur, nxt_e;
	logic [32:0] sum;

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			if (g == 0) begin : g_l
				assign lefts[g] = '0;
			end else begin : g_l
				assign lefts[g] = cells[g-1];
			end
			if (g == SLOTS - 1) begin : g_r
				assign rights[g] = '0;
			end else begin : g_r
				assign rights[g] = cells[g+1];
			end
			dqtt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .my_pos(SW'(g)), .ctl(ctl),
				.left(lefts[g]), .right(rights[g]), .ent(cells[g])
			);
		end
	endgenerate

	assign any_free = (free_hd_q < NIL);

	assign cur = (idx_q < SW'(SLOTS)) ? cells[idx_q[SIW-1:0]] : '0;
	assign nxt_e = (idx_q + 1'b1 < SW'(SLOTS)) ? cells[SIW'(idx_q + 1'b1)] : '0;
	assign sum = {1'b0, nxt_e.delta} + {1'b0, cur.delta};

	assign in_ready = (state_q == S_IDLE) && !out_v_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		rem_d = rem_q;
		nid_d = nid_q;
		ins_d = ins_q;
		per_d = per_q;
		free_hd_d = free_hd_q;
		rel_en = 1'b0;
		rel_id = '0;
		out_d = out_q;
		out_load = 1'b0;
		ctl = '0;
		ctl.cmd = CC_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					out_d = '0;
					idx_d = '0;
					ins_d = 1'b0;
					unique case (func_t'(in_data.func))
						FN_TICK: begin
							ctl.cmd = CC_TICK;
							out_load = 1'b1;
						end
						FN_ADD: begin
							if (!any_free) begin
								out_d.status = ST_FULL;
								out_load = 1'b1;
							end else begin
								free_hd_d = free_nxt_q[free_hd_q[SIW-1:0]];
								nid_d = free_hd_q;
								rem_d = in_data.first_delay;
								per_d = in_data.repeat_period;
								ins_d = 1'b1;
								out_d.slot_id = 4'(free_hd_q);
								state_d = S_SCAN;
							end
						end
						FN_DEL: begin
							if (!cells[0].used) begin
								out_d.status = ST_EMPTY;
								out_load = 1'b1;
							end else begin
								state_d = S_SCAN;
							end
						end
						FN_DISP: begin
							if (cells[0].used && cells[0].delta == 32'd0) begin
								ctl.cmd = CC_POP;
								out_d.slot_id = 4'(cells[0].id);
								out_d.fired = 1'b1;
								if (cells[0].period == 32'd0) begin
									rel_en = 1'b1;
									rel_id = cells[0].id;
									free_hd_d = cells[0].id;
									out_load = 1'b1;
								end else begin
									nid_d = cells[0].id;
									rem_d = cells[0].period;
									per_d = cells[0].period;
									ins_d = 1'b1;
									state_d = S_SCAN;
								end
							end else begin
								out_load = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (ins_q) begin
					if (!cur.used || cur.delta > rem_q) begin
						state_d = S_APPLY;
					end else begin
						rem_d = rem_q - cur.delta;
						idx_d = idx_q + 1'b1;
					end
				end else begin
					if (!cur.used) begin
						out_load = 1'b1;
						state_d = S_IDLE;
					end else if (cur.id == {1'b0, cmd_q.target_id}) begin
						state_d = S_APPLY;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			S_APPLY: begin
				ctl.pos = idx_q;
				if (ins_q) begin
					ctl.cmd = CC_INS;
					ctl.ent.used = 1'b1;
					ctl.ent.id = nid_q;
					ctl.ent.delta = rem_q;
					ctl.ent.period = per_q;
				end else begin
					ctl.cmd = CC_DEL;
					ctl.ent.delta = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					rel_en = 1'b1;
					rel_id = cur.id;
					free_hd_d = cur.id;
				end
				out_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_hd_q <= '0;
			for (int i = 0; i < SLOTS; i++)
				free_nxt_q[i] <= SW'(i + 1);
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_hd_q <= free_hd_d;
			if (rel_en)
				free_nxt_q[rel_id[SIW-1:0]] <= free_hd_q;
			if (out_load)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		rem_q <= rem_d;
		nid_q <= nid_d;
		ins_q <= ins_d;
		per_q <= per_d;
		out_q <= out_d;
		if (in_valid && in_ready)
			cmd_q <= in_data;
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;
endmodule

@@ src/dqtt_checker.sv @@
// Port checker for the delta queue task timer, bound to the top level
`include "assert_macros.svh"
module dqtt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input dqtt_pkg::in_beat_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input dqtt_pkg::out_beat_t out_data
);
	import dqtt_pkg::*;

	`ASSERT_IMP(a_no_take_while_out, out_valid, !in_ready, "beat taken with result pending")
	`ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "drop")
	`ASSERT_IMP(a_fired_no_status, out_valid && out_data.fired, out_data.status == ST_OK, "fired")
	`ASSERT_IMP(a_status_code, out_valid, out_data.status <= ST_EMPTY, "bad status code")
endmodule

bind delta_queue_task_timer dqtt_checker u_dqtt_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the delta queue task timer against a delta-list predictor
module testbench;
	import dqtt_pkg::*;

	class timer_scoreboard;
		ptr_t      nxt[SLOTS];
		logic [31:0] dly[SLOTS];
		logic [31:0] per[SLOTS];
		ptr_t      qh;
		ptr_t      fh;
		out_beat_t due_q[$];
		int        errors;
		int        n_fired;
		int        n_full;
		int        n_empty;
		int        n_checked;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				nxt[i] = ptr_t'(i + 1);
				dly[i] = '0;
				per[i] = '0;
			end
			qh = NIL;
			fh = '0;
		endfunction

		function void free_slot(ptr_t s);
			dly[s] = '0;
			per[s] = '0;
			nxt[s] = fh;
			fh = s;
		endfunction

		function void insert(ptr_t s, logic [31:0] d);
			ptr_t prev;
			ptr_t cur;
			int steps;
			prev = NIL;
			cur = qh;
			steps = 0;
			while (cur < SLOTS && steps < SLOTS) begin
				if (dly[cur] > d) begin
					dly[cur] = dly[cur] - d;
					break;
				end
				d = d - dly[cur];
				prev = cur;
				cur = nxt[cur];
				steps++;
			end
			if (cur >= SLOTS)
				cur = NIL;
			dly[s] = d;
			nxt[s] = cur;
			if (prev < SLOTS)
				nxt[prev] = s;
			else
				qh = s;
		endfunction

		function void note_beat(in_beat_t b);
			out_beat_t r;
			ptr_t s;
			ptr_t prev;
			ptr_t cur;
			ptr_t succ;
			logic [32:0] sum;
			int steps;
			r = '0;
			case (func_t'(b.func))
				FN_TICK: begin
					if (qh < SLOTS && dly[qh] > 0)
						dly[qh] = dly[qh] - 1;
				end
				FN_ADD: begin
					if (fh >= SLOTS) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						s = fh;
						fh = nxt[s];
						if (fh >= SLOTS)
							fh = NIL;
						per[s] = b.repeat_period;
						insert(s, b.first_delay);
						r.slot_id = s[3:0];
					end
				end
				FN_DEL: begin
					if (qh >= SLOTS) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						prev = NIL;
						cur = qh;
						steps = 0;
						while (cur < SLOTS && steps < SLOTS) begin
							if (cur == ptr_t'(b.target_id)) begin
								succ = nxt[cur];
								if (succ < SLOTS) begin
									sum = {1'b0, dly[succ]} + {1'b0, dly[cur]};
									dly[succ] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
								end else begin
									succ = NIL;
								end
								if (prev < SLOTS)
									nxt[prev] = succ;
								else
									qh = succ;
								free_slot(cur);
								break;
							end
							prev = cur;
							cur = nxt[cur];
							steps++;
						end
					end
				end
				default: begin
					s = qh;
					if (s < SLOTS && dly[s] == 0) begin
						qh = nxt[s];
						if (qh >= SLOTS)
							qh = NIL;
						if (per[s] == 0)
							free_slot(s);
						else
							insert(s, per[s]);
						r.slot_id = s[3:0];
						r.fired = 1'b1;
						n_fired++;
					end
				end
			endcase
			due_q.push_back(r);
		endfunction

		function void check_beat(out_beat_t got);
			out_beat_t exp_r;
			n_checked++;
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %p", got);
				return;
			end
			exp_r = due_q.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch at result %0d: expected id %0d fired %0d status %0d,",
						" got id %0d fired %0d status %0d"},
						n_checked, exp_r.slot_id, exp_r.fired, exp_r.status,
						got.slot_id, got.fired, got.status);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	timer_scoreboard sb;
	int        mode;
	logic      smp_valid;
	logic      smp_ready;
	out_beat_t smp_data;

	delta_queue_task_timer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (mode == 2)
			out_ready <= $urandom_range(99) >= 85;
		else if (mode == 3)
			out_ready <= $urandom_range(99) >= 31;
		else
			out_ready <= 1'b1;
	end

	always @(negedge clk) begin
		smp_valid <= out_valid;
		smp_ready <= out_ready;
		smp_data <= out_data;
	end

	always @(posedge clk) begin
		if (arst_n && smp_valid === 1'b1 && smp_ready === 1'b1)
			sb.check_beat(smp_data);
	end

	function automatic in_beat_t mk(func_t f, logic [31:0] fd, logic [31:0] rp, logic [3:0] tid);
		in_beat_t b;
		b.func = f;
		b.first_delay = fd;
		b.repeat_period = rp;
		b.target_id = tid;
		return b;
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int r;
		r = $urandom_range(99);
		b.func = (r < 30) ? FN_ADD : (r < 58) ? FN_TICK : (r < 85) ? FN_DISP : FN_DEL;
		b.first_delay = $urandom;
		b.repeat_period = $urandom;
		b.target_id = 4'($urandom_range(15));
		if (b.func == FN_ADD) begin
			case ($urandom_range(9))
				0: b.first_delay = $urandom;
				1: b.first_delay = '0;
				default: b.first_delay = $urandom_range(6);
			endcase
			case ($urandom_range(3))
				0, 1: b.repeat_period = '0;
				2: b.repeat_period = $urandom_range(1, 8);
				default: b.repeat_period = ($urandom_range(9) == 0) ? $urandom
					: $urandom_range(1, 4);
			endcase
		end
		return b;
	endfunction

	task automatic send(in_beat_t b);
		in_valid <= 1'b1;
		in_data <= b;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		sb.note_beat(b);
		if ((mode == 1 && $urandom_range(99) < 85) || (mode == 3 && $urandom_range(99) < 31)) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ((mode == 1 && $urandom_range(99) < 85) || (mode == 3 && $urandom_range(99) < 31))
				@(posedge clk);
		end
	endtask

	initial begin
		sb = new();
		mode = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(FN_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		send(mk(FN_DISP, '0, '0, '0));
		send(mk(FN_DEL, '0, '0, 4'hF));
		send(mk(FN_ADD, '0, 32'd3, '0));
		send(mk(FN_DISP, '0, '0, '0));
		send(mk(FN_DISP, '0, '0, '0));
		repeat (3) send(mk(FN_TICK, '0, '0, '0));
		send(mk(FN_DISP, '0, '0, '0));
		send(mk(FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		send(mk(FN_ADD, 32'hFFFF_FFFF, '0, '0));
		send(mk(FN_ADD, 32'd5, '0, '0));
		send(mk(FN_DEL, '0, '0, 4'd9));
		send(mk(FN_DEL, '0, '0, 4'd1));
		send(mk(FN_DEL, '0, '0, 4'd0));
		for (int i = 0; i < 17; i++)
			send(mk(FN_ADD, 32'(i % 4), (i % 3 == 0) ? 32'd2 : '0, '0));
		repeat (4) send(mk(FN_DISP, '0, '0, '0));

		for (int ph = 0; ph < 4; ph++) begin
			mode = ph;
			for (int i = 0; i < 200; i++)
				send(rand_beat());
		end
		in_valid <= 1'b0;

		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("checked %0d results: %0d dispatches fired, %0d full adds, %0d empty deletes",
			sb.n_checked, sb.n_fired, sb.n_full, sb.n_empty);
		$display("idle phases: none, sender gaps, receiver stalls, both; %0d errors", sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+src
src/dqtt_pkg.sv
src/dqtt_cell.sv
src/delta_queue_task_timer.sv
src/dqtt_checker.sv
verif/testbench.sv
